>>> sv/sitoa_pkg.sv
// shared types and constants for the signed integer to decimal text block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned CHAR_BITS  = 8;

  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = 8'h2D;

  // double dabble correction
  localparam logic [DIGIT_BITS-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] BCD_ADJ       = 4'd3;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_SKIP,
    EM_DIGIT
  } emit_state_t;

  // handoff from the converter to the emitter
  typedef struct packed {
    logic done;
    logic neg;
  } conv_ctl_t;

endpackage

`default_nettype wire

>>> sv/sitoa_conv.sv
// bit-serial binary to bcd converter (double dabble), one magnitude bit per cycle
// depends on sitoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module sitoa_conv #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  input  wire logic [VALUE_BITS-1:0]                    value,
  output logic                                          busy,
  output sitoa_pkg::conv_ctl_t                          ctl,
  output logic [NDIG*sitoa_pkg::DIGIT_BITS-1:0]         bcd
);

  localparam int unsigned BCD_W = NDIG * sitoa_pkg::DIGIT_BITS;
  localparam int unsigned CW    = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  neg_r, neg_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*sitoa_pkg::DIGIT_BITS +: sitoa_pkg::DIGIT_BITS] >= sitoa_pkg::BCD_ADJ_LIMIT) begin
        bcd_adj[i*sitoa_pkg::DIGIT_BITS +: sitoa_pkg::DIGIT_BITS] =
          bcd_r[i*sitoa_pkg::DIGIT_BITS +: sitoa_pkg::DIGIT_BITS] + sitoa_pkg::BCD_ADJ;
      end else begin
        bcd_adj[i*sitoa_pkg::DIGIT_BITS +: sitoa_pkg::DIGIT_BITS] =
          bcd_r[i*sitoa_pkg::DIGIT_BITS +: sitoa_pkg::DIGIT_BITS];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt  = value[VALUE_BITS-1];
      // magnitude as unsigned, so the most negative value is exact
      mag_nxt  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
      bcd_nxt  = '0;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign ctl.done = done_r;
  assign ctl.neg  = neg_r;
  assign bcd      = bcd_r;

endmodule

`default_nettype wire

>>> sv/sitoa_emit.sv
// character emitter: sign, leading-zero skip, one digit per cycle into an output
// register unless out_ready stalls it; depends on sitoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module sitoa_emit #(
  parameter int unsigned NDIG = 10
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  sitoa_pkg::conv_ctl_t                          ctl,
  input  wire logic [NDIG*sitoa_pkg::DIGIT_BITS-1:0]    bcd,
  output logic                                          busy,
  input  wire logic                                     out_ready,
  output logic                                          out_valid,
  output logic [sitoa_pkg::CHAR_BITS-1:0]               out_character,
  output logic                                          out_last
);

  localparam int unsigned BCD_W = NDIG * sitoa_pkg::DIGIT_BITS;
  localparam int unsigned LW    = $clog2(NDIG + 1);

  sitoa_pkg::emit_state_t          state_r, state_nxt;
  logic [BCD_W-1:0]                dig_r, dig_nxt;
  logic [LW-1:0]                   left_r, left_nxt;
  logic                            oval_r, oval_nxt;
  logic [sitoa_pkg::CHAR_BITS-1:0] ochar_r, ochar_nxt;
  logic                            olast_r, olast_nxt;
  logic                            ld;
  logic [sitoa_pkg::DIGIT_BITS-1:0] top;

  assign ld  = !oval_r || out_ready;
  assign top = dig_r[BCD_W-1 -: sitoa_pkg::DIGIT_BITS];

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    left_nxt  = left_r;
    oval_nxt  = oval_r && !out_ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    case (state_r)
      sitoa_pkg::EM_IDLE: begin
        if (ctl.done) begin
          dig_nxt   = bcd;
          left_nxt  = LW'(NDIG);
          state_nxt = ctl.neg ? sitoa_pkg::EM_SIGN : sitoa_pkg::EM_SKIP;
        end
      end
      sitoa_pkg::EM_SIGN: begin
        if (ld) begin
          oval_nxt  = 1'b1;
          ochar_nxt = sitoa_pkg::CHAR_MINUS;
          olast_nxt = 1'b0;
          state_nxt = sitoa_pkg::EM_SKIP;
        end
      end
      sitoa_pkg::EM_SKIP: begin
        // the lowest digit is always printed, so zero gives one '0'
        if (top == '0 && left_r > LW'(1)) begin
          dig_nxt  = {dig_r[BCD_W-sitoa_pkg::DIGIT_BITS-1:0], {sitoa_pkg::DIGIT_BITS{1'b0}}};
          left_nxt = left_r - LW'(1);
        end else begin
          state_nxt = sitoa_pkg::EM_DIGIT;
        end
      end
      sitoa_pkg::EM_DIGIT: begin
        if (ld) begin
          oval_nxt  = 1'b1;
          ochar_nxt = sitoa_pkg::CHAR_ZERO + {{(sitoa_pkg::CHAR_BITS-sitoa_pkg::DIGIT_BITS){1'b0}}, top};
          olast_nxt = (left_r == LW'(1));
          dig_nxt   = {dig_r[BCD_W-sitoa_pkg::DIGIT_BITS-1:0], {sitoa_pkg::DIGIT_BITS{1'b0}}};
          left_nxt  = left_r - LW'(1);
          if (left_r == LW'(1)) begin
            state_nxt = sitoa_pkg::EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sitoa_pkg::EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitoa_pkg::EM_IDLE;
      oval_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      left_r  <= left_nxt;
    end
    dig_r   <= dig_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign busy          = (state_r != sitoa_pkg::EM_IDLE);
  assign out_valid     = oval_r;
  assign out_character = ochar_r;
  assign out_last      = olast_r;

endmodule

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// top level: signed integer to decimal ascii text, one character per item
// depends on sitoa_pkg, sitoa_conv, sitoa_emit
//
// usage
//  - input channel in_valid/in_ready/in_value takes one two's complement integer
//    of VALUE_BITS bits per item
//  - output channel out_valid/out_ready/out_character/out_last gives its decimal
//    text most significant character first, '-' ahead of negative values,
//    leading zeros dropped, zero as a single '0'; out_last marks the final character
//  - sequence: double dabble over the VALUE_BITS magnitude bits, one bit per cycle,
//    then a handoff to the emitter, which sends '-' for a negative value, skips the
//    leading zeros and then gives one digit per cycle while out_ready stays high
//  - a new item is taken only when both converter and emitter are idle, so one item
//    is through the bit-serial converter and the digit scan before the next starts
//  - the final character sits in the output register, so the next item may be
//    accepted while it waits for out_ready
//  - a stalled receiver holds the emitter in place; no character is dropped
//  - reset (rst_n low, synchronous) clears the control state; output goes invalid
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_character,
  output logic                       out_last
);

  // enough digits for the magnitude 2**(VALUE_BITS-1)
  localparam int unsigned NDIG  = (VALUE_BITS * 3) / 10 + 1;
  localparam int unsigned BCD_W = NDIG * sitoa_pkg::DIGIT_BITS;

  logic                 start;
  logic                 conv_busy;
  logic                 emit_busy;
  sitoa_pkg::conv_ctl_t conv_ctl;
  logic [BCD_W-1:0]     bcd;

  // the done cycle counts as busy so the handoff is never missed
  assign in_ready = !conv_busy && !emit_busy && !conv_ctl.done;
  assign start    = in_valid && in_ready;

  sitoa_conv #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .value (in_value),
    .busy  (conv_busy),
    .ctl   (conv_ctl),
    .bcd   (bcd)
  );

  sitoa_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (conv_ctl),
    .bcd           (bcd),
    .busy          (emit_busy),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

>>> tb/tb_signed_int_to_decimal_ascii.sv
// self-checking testbench for signed_int_to_decimal_ascii: drives integers, predicts
// each decimal character in its own model and checks the text stream item by item
// depends on sitoa_pkg and signed_int_to_decimal_ascii
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned RST_CYCLES = 7;
  // worst case per item: the conversion, 11 characters each behind a receiver stall,
  // and a send gap; about 350 items plus long holds, taken many times
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned LONG_HOLD   = 400;

  // one expected character of the decimal text
  typedef struct packed {
    logic [sitoa_pkg::CHAR_BITS-1:0] ch;
    logic                            last;
  } text_char_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_character;
  logic                  out_last;

  text_char_t  expected_text[$];
  int unsigned error_count;
  int unsigned cycle_count;

  // idling controls for the sender task and the receiver process, set by each test
  bit send_gaps_on;
  bit recv_stalls_on;
  bit long_hold_go;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever begin
      #(CLK_HALF) clk = ~clk;
    end
  end

  // watchdog: a hang or a lost character ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d characters still expected",
             $time, cycle_count, expected_text.size());
    $display("*** FAILED ***");
    $finish;
  end

  // decimal text of one value: optional '-', digits msd first, last on the final one
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic                            neg;
    logic [VALUE_BITS-1:0]           mag;
    logic [sitoa_pkg::CHAR_BITS-1:0] digit_chars[$];
    text_char_t                      tc;
    begin
      neg = value[VALUE_BITS-1];
      // unsigned magnitude, so the most negative value needs no extra bit
      mag = neg ? (~value + 1'b1) : value;
      // least significant digit first; zero still gives one digit
      do begin
        digit_chars.push_front(sitoa_pkg::CHAR_ZERO + sitoa_pkg::CHAR_BITS'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        tc.ch   = sitoa_pkg::CHAR_MINUS;
        tc.last = 1'b0;
        expected_text.push_back(tc);
      end
      foreach (digit_chars[i]) begin
        tc.ch   = digit_chars[i];
        tc.last = (i == digit_chars.size() - 1);
        expected_text.push_back(tc);
      end
    end
  endfunction

  // offer one item, optionally after a random gap, and hold it until taken
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    begin
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
        in_valid = 1'b0;
        in_value = $urandom;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      in_valid = 1'b1;
      in_value = value;
      do begin
        @(posedge clk);
      end while (!in_ready);
      predict_text(value);
      @(negedge clk);
      // valid stays high here; the next send or drain decides what happens
    end
  endtask

  // stop offering, wait for every expected character, then let the block settle
  task automatic drain_text();
    begin
      in_valid = 1'b0;
      while (expected_text.size() != 0) @(negedge clk);
      repeat (TAIL_CYCLES) @(negedge clk);
    end
  endtask

  // random value with a spread of magnitudes and digit counts
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    int unsigned           pow10;
    begin
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = $urandom_range(0, 20);
        2: v = $urandom >> $urandom_range(0, 31);
        3: begin
          pow10 = 1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
          v = pow10 - $urandom_range(0, 1);
        end
        4: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
        default: v = $urandom_range(0, 99999);
      endcase
      // random sign, negation of the top values wraps toward the most negative one
      if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      pick_value = v;
    end
  endfunction

  // extremes, sign handling, zero, digit count boundaries and bit patterns
  task automatic test_directed();
    logic [VALUE_BITS-1:0] corner[$];
    begin
      corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 -32'sd1000000000, 32'd999999999, 32'd1234567890, -32'sd987654321,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'd4294967,
                 -32'sd100000, 32'd7};
      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      foreach (corner[i]) send_value(corner[i]);
      drain_text();
    end
  endtask

  // bulk random values, idling switched on and off in blocks
  task automatic test_random();
    begin
      for (int blk = 0; blk < 7; blk++) begin
        send_gaps_on   = ($urandom_range(0, 2) != 0);
        recv_stalls_on = ($urandom_range(0, 2) != 0);
        repeat (40) send_value(pick_value());
      end
      drain_text();
    end
  endtask

  // receiver holds off for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    begin
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      long_hold_go   = 1'b1;
      repeat (12) send_value(pick_value());
      drain_text();
    end
  endtask

  // last part: no idling on either side
  task automatic test_full_rate();
    begin
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      repeat (30) send_value(pick_value());
      drain_text();
    end
  endtask

  // receiver: random stall bursts, full rate, or one long hold when asked
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_ready    = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // checker: each taken character against the oldest expected one
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h last %b",
                 $time, out_character, out_last);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.ch) begin
          $display("%0t: character mismatch, expected %h got %h",
                   $time, want.ch, out_character);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last flag mismatch, expected %b got %b",
                   $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    error_count    = 0;
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    long_hold_go   = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
